>>> hw/rtl/wenc_pkg.sv
// Shared types, constants and codes for the wheel encoder stamper.
`timescale 1ns / 1ps
`default_nettype none

package wenc_pkg;

  // Stamp ring geometry
  localparam int RING_DEPTH = 8;
  localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // Field widths
  localparam int INDEX_W     = 3;
  localparam int NEWEST_W    = 3;
  localparam int TICK_W      = 16;
  localparam int LIMIT_W     = 8;
  localparam int COUNT_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  // Debounce limit clamp: the top code acts as the one below it
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 8'd255;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP = 8'd254;

  // Register reset values
  localparam logic [LIMIT_W-1:0] DEBOUNCE_RESET   = 8'd12;
  localparam logic [TICK_W-1:0]  STANDSTILL_RESET = 16'd1000;

  typedef enum logic [1:0] {
    CMD_SAMPLE     = 2'd0,
    CMD_STANDSTILL = 2'd1,
    CMD_READ       = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEBOUNCE_LIMIT   = 1'b0,
    CFG_STANDSTILL_TICKS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    cmd_t               command;
    logic               enc_left;
    logic               enc_right;
    logic               fwd_left;
    logic               fwd_right;
    logic [TICK_W-1:0]  tick_now;
    logic               read_side;
    logic [INDEX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] count_left;
    logic signed [COUNT_W-1:0] count_right;
    logic                      update_left;
    logic                      update_right;
    logic                      level_left;
    logic                      level_right;
    logic [NEWEST_W-1:0]       newest_left;
    logic [NEWEST_W-1:0]       newest_right;
    logic [TICK_W-1:0]         stamp_value;
  } out_item_t;

  // Per-channel control from the top level
  typedef struct packed {
    logic               sample;
    logic               standstill;
    logic               level;
    logic               fwd;
    logic [TICK_W-1:0]  tick;
    logic [LIMIT_W-1:0] limit;
    logic [TICK_W-1:0]  threshold;
    logic [INDEX_W-1:0] read_index;
  } chan_ctrl_t;

  // Per-channel status back to the top level
  typedef struct packed {
    logic                taken;
    logic                update;
    logic                level;
    logic [COUNT_W-1:0]  position;
    logic [NEWEST_W-1:0] newest;
    logic [TICK_W-1:0]   stamp;
  } chan_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/wenc_if.sv
// Valid/ready channel interfaces for input and result items.
`timescale 1ns / 1ps
`default_nettype none

interface wenc_in_if;
  import wenc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface wenc_out_if;
  import wenc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/wheel_encoder_debounce_stamper_unit.sv
// Top level of the two-channel wheel encoder debounce and stamp unit.
`timescale 1ns / 1ps
`default_nettype none

// Takes one command item per clock while the result side is not stalled and
// returns one result item per command. The item lands in an input register,
// the two channel units work it out in one pass of logic, and the result
// register holds it until taken. Throughput is one item per cycle, set by the
// single-pass channel update; a stalled result stops the input register,
// which then lowers ready. The user must write registers through cfg_we,
// cfg_index and cfg_data only while no item is in flight; the block does not enforce this.
module wheel_encoder_debounce_stamper_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [wenc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wenc_pkg::CFG_DATA_W-1:0]  cfg_data,
  wenc_in_if.sink                          in_ch,
  wenc_out_if.source                       out_ch
);
  import wenc_pkg::*;

  logic               in_valid_q;
  in_item_t           in_item_q;
  logic               out_valid_q;
  out_item_t          out_item_q;
  out_item_t          result;
  logic               advance;
  logic [LIMIT_W-1:0] debounce_limit;
  logic [TICK_W-1:0]  standstill_ticks;
  chan_ctrl_t         ctrl_left, ctrl_right;
  chan_stat_t         stat_left, stat_right;

  assign advance     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !in_valid_q || advance;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit   <= DEBOUNCE_RESET;
      standstill_ticks <= STANDSTILL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DEBOUNCE_LIMIT:   debounce_limit   <= cfg_data[LIMIT_W-1:0];
        CFG_STANDSTILL_TICKS: standstill_ticks <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the incoming item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_q <= in_ch.item;
    end
  end

  // Drive both channels; a taken left edge skips the right one
  always_comb begin
    ctrl_left.sample      = advance && (in_item_q.command == CMD_SAMPLE);
    ctrl_left.standstill  = advance && (in_item_q.command == CMD_STANDSTILL);
    ctrl_left.level       = in_item_q.enc_left;
    ctrl_left.fwd         = in_item_q.fwd_left;
    ctrl_left.tick        = in_item_q.tick_now;
    ctrl_left.limit       = debounce_limit;
    ctrl_left.threshold   = standstill_ticks;
    ctrl_left.read_index  = in_item_q.read_index;

    ctrl_right.sample     = advance && (in_item_q.command == CMD_SAMPLE) && !stat_left.taken;
    ctrl_right.standstill = ctrl_left.standstill;
    ctrl_right.level      = in_item_q.enc_right;
    ctrl_right.fwd        = in_item_q.fwd_right;
    ctrl_right.tick       = in_item_q.tick_now;
    ctrl_right.limit      = debounce_limit;
    ctrl_right.threshold  = standstill_ticks;
    ctrl_right.read_index = in_item_q.read_index;
  end

  wenc_chan u_chan_left (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl_left),
    .stat (stat_left)
  );

  wenc_chan u_chan_right (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl_right),
    .stat (stat_right)
  );

  // Assemble the result item
  always_comb begin
    result.count_left   = signed'(stat_left.position);
    result.count_right  = signed'(stat_right.position);
    result.update_left  = stat_left.update;
    result.update_right = stat_right.update;
    result.level_left   = stat_left.level;
    result.level_right  = stat_right.level;
    result.newest_left  = stat_left.newest;
    result.newest_right = stat_right.newest;
    result.stamp_value  = '0;
    if (in_item_q.command == CMD_READ) begin
      result.stamp_value = in_item_q.read_side ? stat_right.stamp : stat_left.stamp;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.item  = out_item_q;

endmodule

`default_nettype wire

>>> hw/rtl/wenc_chan.sv
// One encoder channel: debounce, position counter, stamp ring, stale mark.
`timescale 1ns / 1ps
`default_nettype none

module wenc_chan (
  input  logic               clk,
  input  logic               rst,
  input  wenc_pkg::chan_ctrl_t ctrl,
  output wenc_pkg::chan_stat_t stat
);
  import wenc_pkg::*;

  logic                last_level, last_level_next;
  logic [LIMIT_W-1:0]  hold_count, hold_count_next;
  logic [COUNT_W-1:0]  position, position_next;
  logic [SLOT_W-1:0]   newest_slot, newest_slot_next;
  logic [TICK_W-1:0]   newest_stamp, newest_stamp_next;
  logic                stale_mark, stale_mark_next;
  logic [TICK_W-1:0]   ring [RING_DEPTH];

  logic [LIMIT_W-1:0]  lim;
  logic [TICK_W-1:0]   age;
  logic [SLOT_W-1:0]   slot_inc;
  logic                push;
  logic                taken;
  logic                upd;
  logic                lvl_out;
  logic [TICK_W-1:0]   stamp_rd;

  // Next slot in the ring, wrapping at the depth
  assign slot_inc = (newest_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : newest_slot + 1'b1;
  assign lim      = (ctrl.limit == LIMIT_MAX) ? LIMIT_CAP : ctrl.limit;
  assign age      = ctrl.tick - newest_stamp;

  // Qualify edges and check for standstill
  always_comb begin
    last_level_next   = last_level;
    hold_count_next   = hold_count;
    position_next     = position;
    stale_mark_next   = stale_mark;
    push              = 1'b0;
    taken             = 1'b0;
    upd               = 1'b0;
    lvl_out           = 1'b0;
    if (ctrl.sample) begin
      if (ctrl.level != last_level) begin
        last_level_next = ctrl.level;
        hold_count_next = '0;
      end else if (hold_count < lim) begin
        hold_count_next = hold_count + 1'b1;
      end else if (hold_count == lim) begin
        hold_count_next = hold_count + 1'b1;
        taken           = 1'b1;
        push            = 1'b1;
        position_next   = ctrl.fwd ? position + 1'b1 : position - 1'b1;
        if (!stale_mark) begin
          upd     = 1'b1;
          lvl_out = ctrl.level;
        end else begin
          stale_mark_next = 1'b0;
        end
      end
    end else if (ctrl.standstill) begin
      if (age > ctrl.threshold) begin
        push            = 1'b1;
        stale_mark_next = 1'b1;
        upd             = 1'b1;
      end
    end
    newest_slot_next  = push ? slot_inc : newest_slot;
    newest_stamp_next = push ? ctrl.tick : newest_stamp;
  end

  // Read one stamp; entries past the depth read as zero
  always_comb begin
    stamp_rd = '0;
    if (32'(ctrl.read_index) < RING_DEPTH) begin
      stamp_rd = ring[SLOT_W'(ctrl.read_index)];
    end
  end

  // Hold channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level   <= 1'b0;
      hold_count   <= '0;
      position     <= '0;
      newest_slot  <= '0;
      newest_stamp <= '0;
      stale_mark   <= 1'b0;
    end else begin
      last_level   <= last_level_next;
      hold_count   <= hold_count_next;
      position     <= position_next;
      newest_slot  <= newest_slot_next;
      newest_stamp <= newest_stamp_next;
      stale_mark   <= stale_mark_next;
    end
  end

  // Push the tick time into the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i] <= '0;
      end
    end else if (push) begin
      ring[slot_inc] <= ctrl.tick;
    end
  end

  assign stat.taken    = taken;
  assign stat.update   = upd;
  assign stat.level    = lvl_out;
  assign stat.position = position_next;
  assign stat.newest   = NEWEST_W'(newest_slot_next);
  assign stat.stamp    = stamp_rd;

endmodule

`default_nettype wire

>>> hw/rtl/wenc_checker.sv
// Port-level checks for the wheel encoder stamper and their bind.
`timescale 1ns / 1ps
`default_nettype none

module wenc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input wenc_pkg::out_item_t out_item
);
  import wenc_pkg::*;

  // Hold a stalled result item
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // A level is reported only with an update
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_item.level_left || out_item.update_left) &&
                  (!out_item.level_right || out_item.update_right))
    else $error("level reported without update");

  // An accepted item passes the input register and reaches the output when the path is free
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 !out_valid |=> out_valid)
    else $error("accepted item did not reach the output");

  // Drop results out of reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind wheel_encoder_debounce_stamper_unit wenc_checker u_wenc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.item)
);

`default_nettype wire

>>> sim/tb_wheel_encoder_debounce_stamper_unit.sv
// Self-checking testbench for the two-channel wheel encoder debounce and stamp unit.
`timescale 1ns / 1ps

module tb_wheel_encoder_debounce_stamper_unit;
  import wenc_pkg::*;

  localparam int RX_LONG_HOLD = 400;
  localparam int STALL_LIMIT  = 3000;

  typedef struct packed {
    logic      pinned;
    out_item_t want;
  } pin_t;

  typedef struct {
    bit          is_cfg;
    cfg_reg_t    cfg_sel;
    logic [15:0] data;
    in_item_t    item;
    bit          pinned;
    out_item_t   want;
  } dir_row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  wenc_in_if  in_ch ();
  wenc_out_if out_ch ();

  wheel_encoder_debounce_stamper_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Encoder state as the block should hold it
  logic [LIMIT_W-1:0] lim_reg;
  logic [TICK_W-1:0]  thr_reg;
  logic               last_lv [2];
  logic [LIMIT_W-1:0] hold [2];
  logic [COUNT_W-1:0] pos [2];
  logic [TICK_W-1:0]  ring [2][RING_DEPTH];
  logic [SLOT_W-1:0]  head [2];
  logic               stale [2];

  out_item_t   exp_q [$];
  pin_t        pin_q [$];
  dir_row_t    dir_tbl [$];
  int unsigned sent_cnt;
  int unsigned got_cnt;
  int unsigned mismatches;
  int unsigned stall_cnt;
  int unsigned cyc;
  bit          hold_rx_req;
  bit          calm;

  // Stimulus-side wheel state
  logic        lvl_l, lvl_r, dir_l, dir_r;
  logic [15:0] now_tick;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Push a time into a channel's stamp ring
  function automatic void push_time(int c, logic [TICK_W-1:0] t);
    head[c] = (int'(head[c]) == RING_DEPTH - 1) ? '0 : head[c] + 1'b1;
    ring[c][head[c]] = t;
  endfunction

  // Debounce one channel; returns 1 when a qualified edge is taken
  function automatic bit debounce_edge(int c, logic lv, logic fwd, logic [TICK_W-1:0] t,
                                       output logic upd, output logic lvo);
    logic [LIMIT_W-1:0] lim;
    upd = 1'b0;
    lvo = 1'b0;
    lim = (lim_reg == LIMIT_MAX) ? LIMIT_CAP : lim_reg;
    if (lv != last_lv[c]) begin
      last_lv[c] = lv;
      hold[c] = '0;
      return 1'b0;
    end
    if (hold[c] < lim) begin
      hold[c]++;
      return 1'b0;
    end
    if (hold[c] != lim) return 1'b0;
    hold[c]++;
    pos[c] = fwd ? pos[c] + 1'b1 : pos[c] - 1'b1;
    push_time(c, t);
    if (!stale[c]) begin
      upd = 1'b1;
      lvo = lv;
    end else begin
      stale[c] = 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the encoder state by one command and form its result
  function automatic out_item_t wheel_step(in_item_t it);
    out_item_t         r;
    logic [1:0]        upd;
    logic [1:0]        lvl;
    logic [TICK_W-1:0] age;
    r = '0;
    upd = '0;
    lvl = '0;
    case (it.command)
      CMD_SAMPLE: begin
        if (!debounce_edge(0, it.enc_left, it.fwd_left, it.tick_now, upd[0], lvl[0]))
          void'(debounce_edge(1, it.enc_right, it.fwd_right, it.tick_now, upd[1], lvl[1]));
      end
      CMD_STANDSTILL: begin
        for (int c = 0; c < 2; c++) begin
          age = it.tick_now - ring[c][head[c]];
          if (age > thr_reg) begin
            push_time(c, it.tick_now);
            stale[c] = 1'b1;
            upd[c] = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (int'(it.read_index) < RING_DEPTH) r.stamp_value = ring[it.read_side][it.read_index];
      end
      default: ;
    endcase
    r.count_left   = pos[0];
    r.count_right  = pos[1];
    r.update_left  = upd[0];
    r.update_right = upd[1];
    r.level_left   = lvl[0];
    r.level_right  = lvl[1];
    r.newest_left  = NEWEST_W'(head[0]);
    r.newest_right = NEWEST_W'(head[1]);
    return r;
  endfunction

  function automatic void show_field(string name, logic [15:0] w, logic [15:0] g);
    if (w !== g) $display("  %s: expected %0h, got %0h", name, w, g);
  endfunction

  function automatic void check_result(out_item_t got, out_item_t want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on result %0d at %0t ns", got_cnt, $time);
        show_field("count_left", want.count_left, got.count_left);
        show_field("count_right", want.count_right, got.count_right);
        show_field("update_left", 16'(want.update_left), 16'(got.update_left));
        show_field("update_right", 16'(want.update_right), 16'(got.update_right));
        show_field("level_left", 16'(want.level_left), 16'(got.level_left));
        show_field("level_right", 16'(want.level_right), 16'(got.level_right));
        show_field("newest_left", 16'(want.newest_left), 16'(got.newest_left));
        show_field("newest_right", 16'(want.newest_right), 16'(got.newest_right));
        show_field("stamp_value", want.stamp_value, got.stamp_value);
      end
    end
  endfunction

  // Track accepted items, check results, and watch for a hung handshake
  always @(posedge clk) begin : monitor
    out_item_t pred;
    pin_t      pin;
    cyc++;
    stall_cnt++;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        stall_cnt = 0;
        got_cnt++;
        if (exp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with nothing expected at %0t ns", $time);
        end else begin
          check_result(out_ch.item, exp_q.pop_front());
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        stall_cnt = 0;
        pred = wheel_step(in_ch.item);
        pin = (pin_q.size() != 0) ? pin_q.pop_front() : '0;
        exp_q.push_back(pin.pinned ? pin.want : pred);
      end
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: random stalls, one long hold on request
  initial begin : rx_side
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      if (hold_rx_req) begin
        out_ch.ready <= 1'b0;
        hold_rx_req = 1'b0;
        repeat (RX_LONG_HOLD) @(posedge clk);
      end else if (!calm && cyc[7:6] != 2'b00 && $urandom_range(0, 6) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Offer one item and hold it until taken
  task automatic send_item(in_item_t it, logic pinned, out_item_t want);
    pin_q.push_back({pinned, want});
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent_cnt++;
  endtask

  task automatic idle_gap(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop offering and wait until every result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (got_cnt != sent_cnt) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [15:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_DEBOUNCE_LIMIT) lim_reg = val[LIMIT_W-1:0];
    else thr_reg = val;
  endtask

  function automatic void add_cfg(cfg_reg_t sel, logic [15:0] val);
    dir_row_t row;
    row = '{cfg_sel: sel, default: '0};
    row.is_cfg  = 1'b1;
    row.data    = val;
    dir_tbl.push_back(row);
  endfunction

  function automatic void add_item(cmd_t cmd, logic el, er, fl, fr, logic [15:0] tick,
                                   logic side, logic [2:0] idx);
    dir_row_t row;
    row = '{cfg_sel: CFG_DEBOUNCE_LIMIT, default: '0};
    row.item = '{command: cmd, enc_left: el, enc_right: er, fwd_left: fl, fwd_right: fr,
                 tick_now: tick, read_side: side, read_index: idx};
    dir_tbl.push_back(row);
  endfunction

  // Pin the expected result of the row just added
  function automatic void add_pinned(logic [15:0] cl, cr, logic ul, ur, ll, lr,
                                     logic [2:0] nl, nr, logic [15:0] st);
    dir_tbl[dir_tbl.size() - 1].pinned = 1'b1;
    dir_tbl[dir_tbl.size() - 1].want   = '{count_left: cl, count_right: cr,
                                           update_left: ul, update_right: ur,
                                           level_left: ll, level_right: lr,
                                           newest_left: nl, newest_right: nr,
                                           stamp_value: st};
  endfunction

  // One random phase at a fixed register setting
  task automatic run_phase(logic [7:0] lim, logic [15:0] thr, int n, int pct,
                           bit long_rx_hold, bit pause_mid);
    in_item_t it;
    int       r;
    int       lim_eff;
    write_reg(CFG_DEBOUNCE_LIMIT, {8'h00, lim});
    write_reg(CFG_STANDSTILL_TICKS, thr);
    lim_eff = (lim == LIMIT_MAX) ? int'(LIMIT_CAP) : int'(lim);
    if (long_rx_hold) hold_rx_req = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (pause_mid && k == n / 2) drain();
      if (!calm && (k / 40) % 3 != 0 && $urandom_range(0, 5) == 0)
        idle_gap($urandom_range(1, 13));
      // Fields a command ignores still get random values
      it.enc_left   = $urandom_range(0, 1);
      it.enc_right  = $urandom_range(0, 1);
      it.fwd_left   = $urandom_range(0, 1);
      it.fwd_right  = $urandom_range(0, 1);
      it.tick_now   = $urandom_range(0, 65535);
      it.read_side  = $urandom_range(0, 1);
      it.read_index = $urandom_range(0, 7);
      r = $urandom_range(0, 99);
      if (r < pct) begin
        // Mostly steady levels so edges qualify, with the odd glitch
        it.command = CMD_SAMPLE;
        if ($urandom_range(0, 2 * lim_eff + 3) == 0) lvl_l = ~lvl_l;
        if ($urandom_range(0, 2 * lim_eff + 3) == 0) lvl_r = ~lvl_r;
        if ($urandom_range(0, 30) == 0) dir_l = ~dir_l;
        if ($urandom_range(0, 30) == 0) dir_r = ~dir_r;
        it.enc_left  = lvl_l;
        it.enc_right = lvl_r;
        it.fwd_left  = dir_l;
        it.fwd_right = dir_r;
        if (lim_eff < 20 && $urandom_range(0, 11) == 0) it.enc_left = ~lvl_l;
        if (lim_eff < 20 && $urandom_range(0, 11) == 0) it.enc_right = ~lvl_r;
        now_tick   = now_tick + 16'($urandom_range(0, 20));
        it.tick_now = now_tick;
      end else if (r < pct + (100 - pct) / 2) begin
        it.command = CMD_STANDSTILL;
        if ($urandom_range(0, 1) == 1) now_tick = now_tick + 16'($urandom_range(0, 40));
        else now_tick = now_tick + 16'($urandom_range(0, 65535));
        it.tick_now = now_tick;
      end else if (r < 99) begin
        it.command = CMD_READ;
      end else begin
        it.command = CMD_NOP;
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  initial begin : main_seq
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_DEBOUNCE_LIMIT;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.item  <= '0;
    hold_rx_req = 1'b0;
    calm        = 1'b0;
    sent_cnt    = 0;
    got_cnt     = 0;
    mismatches  = 0;
    stall_cnt   = 0;
    cyc         = 0;
    lvl_l = 1'b0;
    lvl_r = 1'b0;
    dir_l = 1'b1;
    dir_r = 1'b0;
    now_tick = '0;

    // Reset state of the block
    lim_reg = DEBOUNCE_RESET;
    thr_reg = STANDSTILL_RESET;
    for (int c = 0; c < 2; c++) begin
      last_lv[c] = 1'b0;
      hold[c]    = '0;
      pos[c]     = '0;
      head[c]    = '0;
      stale[c]   = 1'b0;
      for (int j = 0; j < RING_DEPTH; j++) ring[c][j] = '0;
    end

    // Directed part: reset values, standstill boundary, limit extremes
    add_item(CMD_NOP, 0, 0, 0, 0, 16'h0000, 0, 3'd0);
    add_pinned(16'd0, 16'd0, 0, 0, 0, 0, 3'd0, 3'd0, 16'd0);
    add_item(CMD_READ, 0, 0, 0, 0, 16'h0000, 1, 3'd7);
    add_pinned(16'd0, 16'd0, 0, 0, 0, 0, 3'd0, 3'd0, 16'd0);
    add_item(CMD_STANDSTILL, 0, 0, 0, 0, 16'd1000, 0, 3'd0);
    add_pinned(16'd0, 16'd0, 0, 0, 0, 0, 3'd0, 3'd0, 16'd0);
    add_item(CMD_STANDSTILL, 0, 0, 0, 0, 16'd1001, 0, 3'd0);
    add_pinned(16'd0, 16'd0, 1, 1, 0, 0, 3'd1, 3'd1, 16'd0);
    add_item(CMD_READ, 0, 0, 0, 0, 16'h0000, 0, 3'd1);
    add_pinned(16'd0, 16'd0, 0, 0, 0, 0, 3'd1, 3'd1, 16'd1001);
    add_cfg(CFG_DEBOUNCE_LIMIT, 16'd0);
    add_item(CMD_SAMPLE, 1, 1, 1, 0, 16'd5, 0, 3'd0);
    add_item(CMD_SAMPLE, 1, 1, 1, 0, 16'd6, 0, 3'd0);
    add_item(CMD_SAMPLE, 1, 1, 1, 0, 16'd7, 0, 3'd0);
    add_item(CMD_SAMPLE, 0, 0, 0, 1, 16'd8, 0, 3'd0);
    add_item(CMD_SAMPLE, 0, 0, 0, 1, 16'hffff, 0, 3'd0);
    add_item(CMD_SAMPLE, 0, 0, 0, 1, 16'h0000, 0, 3'd0);
    add_item(CMD_SAMPLE, 1, 1, 1, 1, 16'd1, 0, 3'd0);
    add_item(CMD_SAMPLE, 1, 1, 1, 1, 16'd2, 0, 3'd0);
    add_cfg(CFG_STANDSTILL_TICKS, 16'd0);
    add_item(CMD_STANDSTILL, 0, 0, 0, 0, 16'h0001, 0, 3'd0);
    add_cfg(CFG_STANDSTILL_TICKS, 16'hffff);
    add_item(CMD_STANDSTILL, 0, 0, 0, 0, 16'h8000, 0, 3'd0);
    add_cfg(CFG_DEBOUNCE_LIMIT, 16'd255);
    add_item(CMD_READ, 0, 0, 0, 0, 16'h0000, 1, 3'd0);
    add_item(CMD_READ, 0, 0, 0, 0, 16'h0000, 0, 3'd7);
    add_item(CMD_NOP, 1, 1, 1, 1, 16'hffff, 1, 3'd7);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].is_cfg) write_reg(dir_tbl[i].cfg_sel, dir_tbl[i].data);
      else send_item(dir_tbl[i].item, dir_tbl[i].pinned, dir_tbl[i].want);
    end

    // Random phases across register settings, extremes included
    run_phase(8'd0, 16'd0, 160, 75, 1'b0, 1'b0);
    run_phase(8'd1, 16'hffff, 160, 75, 1'b0, 1'b0);
    run_phase(8'd2, 16'd7, 160, 75, 1'b1, 1'b0);
    run_phase(8'd5, 16'd300, 160, 70, 1'b0, 1'b1);
    run_phase(8'd255, 16'd1000, 290, 95, 1'b0, 1'b0);
    run_phase(8'($urandom_range(1, 8)), 16'($urandom_range(1, 65534)), 160, 75, 1'b0, 1'b0);
    calm = 1'b1;
    run_phase(8'd3, 16'd100, 160, 75, 1'b0, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && got_cnt == sent_cnt && exp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> wheel_encoder_debounce_stamper_unit.f
hw/rtl/wenc_pkg.sv
hw/rtl/wenc_if.sv
hw/rtl/wenc_chan.sv
hw/rtl/wheel_encoder_debounce_stamper_unit.sv
hw/rtl/wenc_checker.sv
sim/tb_wheel_encoder_debounce_stamper_unit.sv
